/* design/pwsg_pkg.sv */
// Shared types and constants of the wavetable sound generator.
// No dependencies; pwsg_front, pwsg_back and the top level import this package.
`default_nettype none
package pwsg_pkg;

	// input function codes
	localparam logic [2:0] FUNC_REG_WR = 3'd0;
	localparam logic [2:0] FUNC_REG_RD = 3'd1;
	localparam logic [2:0] FUNC_MEM_WR = 3'd2;
	localparam logic [2:0] FUNC_MEM_RD = 3'd3;
	localparam logic [2:0] FUNC_TICK   = 3'd4;

	// channel register indexes
	localparam logic [3:0] REG_ENV     = 4'd0;
	localparam logic [3:0] REG_PAN     = 4'd1;
	localparam logic [3:0] REG_FREQ_LO = 4'd2;
	localparam logic [3:0] REG_FREQ_HI = 4'd3;
	localparam logic [3:0] REG_LOOP_LO = 4'd4;
	localparam logic [3:0] REG_LOOP_HI = 4'd5;
	localparam logic [3:0] REG_PAGE    = 4'd6;
	localparam logic [3:0] REG_CTRL    = 4'd7;
	localparam logic [3:0] REG_ONOFF   = 4'd8;

	// configuration register indexes
	localparam logic [1:0] CFG_RATE  = 2'd0;
	localparam logic [1:0] CFG_ZPAT  = 2'd1;
	localparam logic [1:0] CFG_MUTE  = 2'd2;

	localparam logic [7:0] LOOP_MARK = 8'hFF;
	localparam logic [15:0] RATE_RESET = 16'h1000;

	typedef enum logic [2:0] {
		OP_REG_WR,
		OP_REG_RD,
		OP_MEM_WR,
		OP_MEM_RD,
		OP_TICK,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  reg_req;
		logic [7:0]  data;
		logic [15:0] offset;
	} cmd_t;

	typedef struct packed {
		logic        pop;
		logic        clearing;
	} back_st_t;

	typedef struct packed {
		logic [15:0] rate_ratio;
		logic        zero_patch;
		logic [7:0]  mute_mask;
	} cfg_t;

	typedef enum logic [3:0] {
		B_CLR,
		B_IDLE,
		B_MRD,
		B_CH,
		B_S1,
		B_S2,
		B_PLAY,
		B_ACC,
		B_SCAN,
		B_FIN,
		B_OUT
	} bstate_t;

endpackage
`default_nettype wire

/* design/pwsg_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`default_nettype none
interface pwsg_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [3:0]  reg_req;
	logic [7:0]  data;
	logic [15:0] offset;
	modport source (output valid, func, reg_req, data, offset, input ready);
	modport sink (input valid, func, reg_req, data, offset, output ready);
endinterface

interface pwsg_rsp_if;
	logic               valid;
	logic               ready;
	logic [7:0]         read_data;
	logic signed [17:0] left_sample;
	logic signed [17:0] right_sample;
	modport source (output valid, read_data, left_sample, right_sample, input ready);
	modport sink (input valid, read_data, left_sample, right_sample, output ready);
endinterface
`default_nettype wire

/* design/pwsg_front.sv */
// Front end: accepts requests, decodes the function code, two-entry queue.
// Depends on pwsg_pkg and pwsg_if.
`default_nettype none
module pwsg_front (
	input  wire                 clk,
	input  wire                 arst_n,
	pwsg_req_if.sink            req,
	input  pwsg_pkg::back_st_t  st,
	output logic                q_valid,
	output pwsg_pkg::cmd_t      q_cmd
);
	import pwsg_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push, pop;

	// decode the function code
	always_comb begin
		dec.reg_req = req.reg_req;
		dec.data    = req.data;
		dec.offset  = req.offset;
		case (req.func)
			FUNC_REG_WR: dec.op = OP_REG_WR;
			FUNC_REG_RD: dec.op = OP_REG_RD;
			FUNC_MEM_WR: dec.op = OP_MEM_WR;
			FUNC_MEM_RD: dec.op = OP_MEM_RD;
			FUNC_TICK:   dec.op = OP_TICK;
			default:     dec.op = OP_NOP;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2) && !st.clearing;
	assign push      = req.valid && req.ready;
	assign q_valid   = cnt_q != 2'd0;
	assign q_cmd     = ent_q[rp_q];
	assign pop       = st.pop && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= dec;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/pwsg_back.sv */
// Back end: channel registers, wave memory, tick sequencer, response register.
// Depends on pwsg_pkg and pwsg_if.
`default_nettype none
module pwsg_back #(
	parameter int NUM_CHANNELS  = 8,
	parameter int RAM_BYTES     = 65536,
	parameter int FRACTION_BITS = 11
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  logic                q_valid,
	input  pwsg_pkg::cmd_t      q_cmd,
	input  pwsg_pkg::cfg_t      cfg,
	output pwsg_pkg::back_st_t  st,
	pwsg_rsp_if.source          rsp
);
	import pwsg_pkg::*;

	localparam int AW    = $clog2(RAM_BYTES);
	localparam int POS_W = 16 + FRACTION_BITS;
	localparam logic [2:0]    LAST_CH  = 3'(NUM_CHANNELS - 1);
	localparam logic [AW-1:0] LAST_ADR = AW'(RAM_BYTES - 1);

	// address modulo memory size; quotient is at most 15
	function automatic logic [AW-1:0] ram_idx(input logic [15:0] x);
		logic [4:0]  q;
		logic [20:0] r;
		q = 5'd0;
		for (int i = 1; i < 16; i++) begin
			if (21'(x) >= 21'(i * RAM_BYTES)) q = 5'(i);
		end
		r = 21'(x) - 21'({16'd0, q} * 21'(RAM_BYTES));
		return r[AW-1:0];
	endfunction

	bstate_t state_q, state_d;

	// channel registers
	logic [7:0]       env_q  [8];
	logic [7:0]       pan_q  [8];
	logic [15:0]      freq_q [8];
	logic [15:0]      loop_q [8];
	logic [7:0]       page_q [8];
	logic [POS_W-1:0] pos_q  [8];
	logic [7:0]       on_q;
	logic             snd_en_q;
	logic [2:0]       sel_q;
	logic [3:0]       bank_q;

	// sequencer datapath
	logic [2:0]         ch_q;
	logic [AW-1:0]      clr_q;
	logic [7:0]         raw_q;
	logic [15:0]        addr_q, na_q;
	logic [16:0]        k_q;
	logic [19:0]        step_q;
	logic [6:0]         mull_q, mulr_q;
	logic signed [8:0]  val_q;
	logic signed [17:0] suml_q, sumr_q;
	logic [7:0]         rd_q;

	// wave memory
	logic [7:0]    ram_q [RAM_BYTES];
	logic [7:0]    rdata_q;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;

	always_ff @(posedge clk) begin
		if (ram_we) ram_q[ram_addr] <= ram_wdata;
		if (ram_re) rdata_q <= ram_q[ram_addr];
	end

	// shared decode
	logic [2:0]       ridx;
	logic [POS_W-1:0] cpos, lpos, npos;
	logic [15:0]      cloop, caddr, naddr, host_adr;
	logic             playing, mark, last_ch, out_free, scan_more;
	logic [16:0]      k_first, k_next;
	logic [31:0]      prod;
	logic [11:0]      pl, pr;
	logic signed [16:0] pv_l, pv_r;

	assign ridx      = (state_q == B_IDLE) ? q_cmd.reg_req[3:1] : ch_q;
	assign cpos      = pos_q[ridx];
	assign cloop     = loop_q[ch_q];
	assign lpos      = {cloop, FRACTION_BITS'(0)};
	assign caddr     = cpos[POS_W-1:FRACTION_BITS];
	assign npos      = cpos + POS_W'(step_q);
	assign naddr     = npos[POS_W-1:FRACTION_BITS];
	assign host_adr  = {bank_q, 12'd0} | q_cmd.offset;
	assign playing   = on_q[ch_q] && !cfg.mute_mask[ch_q];
	assign mark      = rdata_q == LOOP_MARK;
	assign last_ch   = ch_q == LAST_CH;
	assign out_free  = !rsp.valid || rsp.ready;
	assign k_first   = {1'b0, addr_q} + 17'd1;
	assign k_next    = k_q + 17'd1;
	assign scan_more = k_next < {1'b0, na_q};
	assign prod      = freq_q[ch_q] * cfg.rate_ratio;
	assign pl        = env_q[ch_q] * pan_q[ch_q][3:0];
	assign pr        = env_q[ch_q] * pan_q[ch_q][7:4];
	assign pv_l      = val_q * $signed({1'b0, mull_q});
	assign pv_r      = val_q * $signed({1'b0, mulr_q});

	assign st.clearing = state_q == B_CLR;
	assign st.pop      = state_q == B_IDLE && q_valid;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLR:  if (clr_q == LAST_ADR) state_d = B_IDLE;
			B_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_MEM_RD: state_d = B_MRD;
						OP_TICK:   state_d = snd_en_q ? B_CH : B_OUT;
						default:   state_d = B_OUT;
					endcase
				end
			end
			B_MRD:  state_d = B_OUT;
			B_CH: begin
				if (playing) state_d = B_S1;
				else state_d = last_ch ? B_OUT : B_CH;
			end
			B_S1:   state_d = mark ? B_S2 : B_PLAY;
			B_S2: begin
				if (mark) state_d = last_ch ? B_OUT : B_CH;
				else state_d = B_PLAY;
			end
			B_PLAY: state_d = B_ACC;
			B_ACC:  state_d = (k_first < {1'b0, naddr}) ? B_SCAN : B_FIN;
			B_SCAN: if (mark || !scan_more) state_d = B_FIN;
			B_FIN:  state_d = last_ch ? B_OUT : B_CH;
			B_OUT:  if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = ram_idx(host_adr);
		ram_wdata = q_cmd.data;
		case (state_q)
			B_CLR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = 8'd0;
			end
			B_IDLE: begin
				ram_we = q_valid && q_cmd.op == OP_MEM_WR;
				ram_re = q_valid && q_cmd.op == OP_MEM_RD;
			end
			B_CH: begin
				ram_re   = playing;
				ram_addr = ram_idx(caddr);
			end
			B_S1: begin
				ram_re   = mark;
				ram_addr = ram_idx(cloop);
			end
			B_ACC: begin
				ram_re   = 1'b1;
				ram_addr = (k_first < {1'b0, naddr}) ? ram_idx(k_first[15:0]) :
					ram_idx(naddr);
			end
			B_SCAN: begin
				ram_re = 1'b1;
				if (mark) ram_addr = ram_idx(cloop);
				else if (scan_more) ram_addr = ram_idx(k_next[15:0]);
				else ram_addr = ram_idx(na_q);
			end
			default: ;
		endcase
	end

	// state and channel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLR;
			clr_q    <= '0;
			ch_q     <= 3'd0;
			on_q     <= 8'd0;
			snd_en_q <= 1'b0;
			sel_q    <= 3'd0;
			bank_q   <= 4'd0;
			for (int i = 0; i < 8; i++) begin
				env_q[i]  <= 8'd0;
				pan_q[i]  <= 8'd0;
				freq_q[i] <= 16'd0;
				loop_q[i] <= 16'd0;
				page_q[i] <= 8'd0;
				pos_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				B_CLR: clr_q <= clr_q + AW'(1);
				B_IDLE: begin
					ch_q <= 3'd0;
					if (q_valid && q_cmd.op == OP_REG_WR) begin
						case (q_cmd.reg_req)
							REG_ENV:     env_q[sel_q] <= q_cmd.data;
							REG_PAN:     pan_q[sel_q] <= q_cmd.data;
							REG_FREQ_LO: freq_q[sel_q][7:0] <= q_cmd.data;
							REG_FREQ_HI: freq_q[sel_q][15:8] <= q_cmd.data;
							REG_LOOP_LO: loop_q[sel_q][7:0] <= q_cmd.data;
							REG_LOOP_HI: loop_q[sel_q][15:8] <= q_cmd.data;
							REG_PAGE:    page_q[sel_q] <= q_cmd.data;
							REG_CTRL: begin
								if (q_cmd.data[6]) sel_q <= q_cmd.data[2:0];
								else bank_q <= q_cmd.data[3:0];
								snd_en_q <= q_cmd.data[7];
							end
							REG_ONOFF: begin
								for (int i = 0; i < 8; i++) begin
									if (!on_q[i])
										pos_q[i] <= {page_q[i], 8'd0, FRACTION_BITS'(0)};
								end
								on_q <= ~q_cmd.data;
							end
							default: ;
						endcase
					end
				end
				B_CH: if (!playing) ch_q <= ch_q + 3'd1;
				B_S1: if (mark) pos_q[ch_q] <= lpos;
				B_S2: if (mark) ch_q <= ch_q + 3'd1;
				B_ACC: pos_q[ch_q] <= npos;
				B_SCAN: if (mark) pos_q[ch_q] <= lpos;
				B_FIN: begin
					if (mark) pos_q[ch_q] <= lpos;
					ch_q <= ch_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				rd_q   <= 8'd0;
				suml_q <= '0;
				sumr_q <= '0;
				if (q_cmd.op == OP_REG_RD)
					rd_q <= q_cmd.reg_req[0] ? caddr[15:8] : caddr[7:0];
			end
			B_MRD: rd_q <= rdata_q;
			B_CH: addr_q <= caddr;
			B_S1: begin
				raw_q <= rdata_q;
				if (mark) addr_q <= cloop;
			end
			B_S2: raw_q <= rdata_q;
			B_PLAY: begin
				mull_q <= pl[11:5];
				mulr_q <= pr[11:5];
				step_q <= prod[31:12];
				if (raw_q[7]) val_q <= -$signed({2'b00, raw_q[6:0]});
				else if (raw_q == 8'd0 && cfg.zero_patch) val_q <= -9'sd127;
				else val_q <= $signed({1'b0, raw_q});
			end
			B_ACC: begin
				suml_q <= suml_q + 18'(pv_l);
				sumr_q <= sumr_q + 18'(pv_r);
				na_q   <= naddr;
				k_q    <= k_first;
			end
			B_SCAN: k_q <= k_next;
			default: ;
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (state_q == B_OUT && out_free) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_OUT && out_free) begin
			rsp.read_data    <= rd_q;
			rsp.left_sample  <= suml_q;
			rsp.right_sample <= sumr_q;
		end
	end
endmodule
`default_nettype wire

/* design/pcm_wavetable_sound_generator_core.sv */
// Top level of the eight-channel wavetable sound generator.
// Depends on pwsg_pkg, pwsg_if, pwsg_front and pwsg_back.
//
// Requests arrive on req (valid/ready): register write, position read, wave
// memory write, wave memory read or sample tick. Every request gives exactly
// one response on rsp, in order, holding read_data and the left/right mix.
// Configuration (rate ratio, zero-sample patch, mute mask) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce.
//
// A tick with sound enabled visits every channel in turn; for each playing
// channel it reads the byte at its position, taking the loop address on a
// loop marker, then scans the bytes up to the new position for a marker.
// The per-channel sequencer works through the single-port wave memory.
// One request is worked at a time; a two-entry queue keeps accepting behind it.
//
// After reset the wave memory is cleared, one byte a cycle, with req.ready low.
// A stalled rsp holds its data; the queue fills and then req.ready drops.
`default_nettype none
module pcm_wavetable_sound_generator_core #(
	parameter int NUM_CHANNELS  = 8,
	parameter int RAM_BYTES     = 65536,
	parameter int FRACTION_BITS = 11
) (
	input  wire         clk,
	input  wire         arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	pwsg_req_if.sink    req,
	pwsg_rsp_if.source  rsp
);
	import pwsg_pkg::*;

	cfg_t     cfg_q;
	back_st_t st;
	logic     q_valid;
	cmd_t     q_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_ratio <= RATE_RESET;
			cfg_q.zero_patch <= 1'b0;
			cfg_q.mute_mask  <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RATE: cfg_q.rate_ratio <= cfg_data;
				CFG_ZPAT: cfg_q.zero_patch <= cfg_data[0];
				CFG_MUTE: cfg_q.mute_mask  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	pwsg_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.st      (st),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	pwsg_back #(
		.NUM_CHANNELS  (NUM_CHANNELS),
		.RAM_BYTES     (RAM_BYTES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.cfg     (cfg_q),
		.st      (st),
		.rsp     (rsp)
	);

	// no transfer accepted during the memory clear
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		st.clearing |-> !req.ready)
		else $error("request accepted during memory clear");

	// nothing leaves the queue during the memory clear
	a_clear_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		st.clearing |-> !st.pop)
		else $error("queue popped during memory clear");

	// rate ratio takes the written value
	a_rate_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == CFG_RATE |=> cfg_q.rate_ratio == $past(cfg_data))
		else $error("rate ratio write lost");
endmodule
`default_nettype wire
